[src/lxcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxcp_pkg
// shared constants for the lagged cross-correlation peak block
// ----------------------------------------------------------------------------
package lxcp_pkg;
    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_LAGS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
    localparam int CNT_BITS    = ADDR_BITS + 1;
    localparam int LAG_BITS    = 6;
    localparam int CORR_BITS   = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LAG_ERR  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
endpackage

[src/lagged_cross_correlation_peak.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_cross_correlation_peak
// time-lagged pearson cross-correlation over a stored set, with peak tracking
// ----------------------------------------------------------------------------
// Sample pairs load at one item per cycle into two 1024-entry sample rams.
// On the item marked final the block drops s_axis_tready and runs its
// correlation pass. For each lag L it streams the m = n-L stored pairs through
// one shared 32x32 multiplier. It then works out the covariance and variance
// terms with nine products, since m times a sum is taken in two halves. Two
// square roots follow, then the product of the roots and a restoring divider
// over 64 quotient bits and 15 fraction bits. One state starts the lag and
// one emits it. When a variance is zero the roots and the division are
// skipped, and with fewer than two pairs the lag goes straight to its emit.
// One result item per lag (a single error item when lag_limit is not below
// the pair count) leaves through an output register, and a stalled receiver
// holds the pass at the next emit. The block accepts no input until the
// whole set has been delivered. lag_limit is read at the final item.
// ----------------------------------------------------------------------------
module lagged_cross_correlation_peak (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,      // lag_limit [5:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // lead_sample [15:0], follow_sample [31:16]
    input  logic        s_axis_tlast,    // final_pair
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // lag_index, corr_value, peak_lag, peak_corr
    output logic [1:0]  m_axis_tuser,    // status_code
    output logic        m_axis_tlast     // run_end
);
    import lxcp_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_LAGINIT, S_ACC, S_TERMS, S_SQX, S_SQY, S_DEN, S_DIV, S_EMIT, S_WAIT
    } t_state;

    t_state r_state;
    logic [LAG_BITS-1:0]  r_limit_cfg, r_limit, r_lag, r_plag;
    logic [CNT_BITS-1:0]  r_cnt, r_n;
    logic                 r_ovf, r_st_ovf;
    logic [CNT_BITS-1:0]  r_m, r_issue, r_got;
    logic [1:0]           r_ph;
    logic signed [63:0]   r_sx, r_sy, r_sxx, r_syy, r_sxy, r_cov, r_vx, r_vy;
    logic signed [CORR_BITS-1:0] r_pc, r_corr;
    logic [16:0]          r_pmag;
    logic [3:0]           r_tstep;
    logic signed [31:0]   r_ma, r_mb;
    logic [63:0]          r_sqv, r_root, r_bit, r_rx;
    logic [63:0]          r_den, r_rem, r_quo;
    logic [6:0]           r_dstep;
    logic                 r_neg;
    logic                 r_ov;

    // sample rams
    logic [ADDR_BITS-1:0] w_raddr_x, w_raddr_y;
    logic [SAMPLE_BITS-1:0] w_x, w_y;
    logic w_we;
    assign w_we = s_axis_tvalid && s_axis_tready && (r_cnt < CNT_BITS'(MAX_SAMPLES));
    assign w_raddr_x = r_issue[ADDR_BITS-1:0];
    assign w_raddr_y = ADDR_BITS'(r_issue + CNT_BITS'(r_lag));

    lxcp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_lead (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_cnt[ADDR_BITS-1:0]),
        .i_wdata(s_axis_tdata[15:0]), .i_raddr(w_raddr_x), .o_rdata(w_x));
    lxcp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_follow (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_cnt[ADDR_BITS-1:0]),
        .i_wdata(s_axis_tdata[31:16]), .i_raddr(w_raddr_y), .o_rdata(w_y));

    // one shared 32x32 signed multiplier
    logic signed [63:0] w_prod;
    logic signed [63:0] r_prod;
    assign w_prod = 64'(r_ma * r_mb);

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == S_LOAD);

    logic [LAG_BITS-1:0] w_lim;
    assign w_lim = r_limit_cfg; // six bits already cap at MAX_LAGS - 1

    logic [63:0] w_trial, w_acov;
    logic [64:0] w_rsh;
    logic        w_ge;
    logic signed [CORR_BITS-1:0] w_c;
    logic [16:0] w_mag;
    logic [63:0] w_sqsum;
    logic signed [63:0] w_sxy_end;
    assign w_sqsum = r_root + r_bit;
    assign w_rsh = {r_rem, r_quo[63]};
    assign w_ge = (w_rsh >= {1'b0, r_den});
    assign w_sxy_end = r_sxy + r_prod;

    always_comb begin
        if (r_neg) begin
            w_c = (r_ov || r_quo >= 64'd32768) ? -16'sd32768 : -$signed(r_quo[15:0]);
        end else begin
            w_c = (r_ov || r_quo >= 64'd32767) ? 16'sd32767 : $signed(r_quo[15:0]);
        end
        w_mag = r_corr[15] ? 17'(-$signed({r_corr[15], r_corr})) : 17'({1'b0, r_corr});
        w_acov = r_cov[63] ? 64'(-r_cov) : 64'(r_cov);
        w_trial = 64'(w_rsh - {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_limit_cfg <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_limit_cfg <= i_cfg_data[LAG_BITS-1:0];
            unique case (r_state)
                S_LOAD: begin
                    if (s_axis_tvalid) begin
                        if (r_cnt < CNT_BITS'(MAX_SAMPLES)) r_cnt <= r_cnt + 1'b1;
                        if (s_axis_tlast) begin
                            r_n <= (r_cnt < CNT_BITS'(MAX_SAMPLES)) ? r_cnt + 1'b1 : r_cnt;
                            r_st_ovf <= r_ovf || (r_cnt >= CNT_BITS'(MAX_SAMPLES));
                            r_cnt <= '0;
                            r_ovf <= 1'b0;
                            r_limit <= w_lim;
                            r_lag <= '0;
                            r_plag <= '0;
                            r_pc <= '0;
                            r_pmag <= '0;
                            r_state <= S_LAGINIT;
                        end else if (r_cnt >= CNT_BITS'(MAX_SAMPLES)) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_LAGINIT: begin
                    if (CNT_BITS'(r_limit) >= r_n) begin
                        m_axis_tdata <= '0;
                        m_axis_tuser <= ST_LAG_ERR;
                        m_axis_tlast <= 1'b1;
                        m_axis_tvalid <= 1'b1;
                        r_state <= S_WAIT;
                    end else begin
                        r_m <= r_n - CNT_BITS'(r_lag);
                        r_issue <= '0; r_got <= '0; r_ph <= '0;
                        r_sx <= '0; r_sy <= '0; r_sxx <= '0; r_syy <= '0; r_sxy <= '0;
                        r_corr <= '0;
                        if (r_n - CNT_BITS'(r_lag) < CNT_BITS'(2)) r_state <= S_EMIT;
                        else r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    // phase 0 issue read, 1 data: xx, 2 yy, 3 xy
                    unique case (r_ph)
                        2'd0: begin
                            r_ph <= 2'd1;
                        end
                        2'd1: begin
                            r_ma <= 32'($signed(w_x)); r_mb <= 32'($signed(w_x));
                            r_sx <= r_sx + 64'($signed(w_x));
                            r_sy <= r_sy + 64'($signed(w_y));
                            r_ph <= 2'd2;
                        end
                        2'd2: begin
                            r_ma <= 32'($signed(w_y)); r_mb <= 32'($signed(w_y));
                            r_ph <= 2'd3;
                        end
                        default: begin
                            r_sxx <= r_sxx + r_prod;
                            r_ma <= 32'($signed(w_x)); r_mb <= 32'($signed(w_y));
                            r_ph <= 2'd0;
                            r_issue <= r_issue + 1'b1;
                            r_got <= r_got + 1'b1;
                        end
                    endcase
                    if (r_ph == 2'd0 && r_got != '0) r_syy <= r_syy + r_prod;
                    if (r_ph == 2'd1 && r_got != '0) r_sxy <= r_sxy + r_prod;
                    if (r_ph == 2'd0 && r_got == r_m) begin
                        r_ph <= 2'd0;
                        r_tstep <= '0;
                        r_state <= S_TERMS;
                    end
                end
                S_TERMS: begin
                    // pipeline: operands are registered in r_ma and r_mb, and the product is registered in r_prod
                    // m times a sum is taken as upper part shifted by 31 plus lower 31 bits
                    r_tstep <= r_tstep + 1'b1;
                    case (r_tstep)
                        4'd0: begin
                            r_sxy <= w_sxy_end; // last xy product
                            r_ma <= 32'(r_m); r_mb <= 32'(w_sxy_end >>> 31);
                        end
                        4'd1: begin r_ma <= 32'(r_m); r_mb <= {1'b0, r_sxy[30:0]}; end
                        4'd2: begin
                            r_cov <= r_prod <<< 31; r_ma <= r_sx[31:0]; r_mb <= r_sy[31:0];
                        end
                        4'd3: begin
                            r_cov <= r_cov + r_prod;
                            r_ma <= 32'(r_m); r_mb <= 32'(r_sxx >>> 31);
                        end
                        4'd4: begin
                            r_cov <= r_cov - r_prod;
                            r_ma <= 32'(r_m); r_mb <= {1'b0, r_sxx[30:0]};
                        end
                        4'd5: begin
                            r_vx <= r_prod <<< 31; r_ma <= r_sx[31:0]; r_mb <= r_sx[31:0];
                        end
                        4'd6: begin
                            r_vx <= r_vx + r_prod;
                            r_ma <= 32'(r_m); r_mb <= 32'(r_syy >>> 31);
                        end
                        4'd7: begin
                            r_vx <= r_vx - r_prod;
                            r_ma <= 32'(r_m); r_mb <= {1'b0, r_syy[30:0]};
                        end
                        4'd8: begin
                            r_vy <= r_prod <<< 31; r_ma <= r_sy[31:0]; r_mb <= r_sy[31:0];
                        end
                        4'd9: begin r_vy <= r_vy + r_prod; end
                        default: begin
                            r_vy <= r_vy - r_prod;
                            if (r_vx <= 0 || (r_vy - r_prod) <= 0) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_sqv <= r_vx; r_root <= '0; r_bit <= 64'd1 << 62;
                                r_state <= S_SQX;
                            end
                        end
                    endcase
                end
                S_SQX, S_SQY: begin
                    if (r_bit == '0) begin
                        if (r_state == S_SQX) begin
                            r_rx <= r_root;
                            r_sqv <= r_vy; r_root <= '0; r_bit <= 64'd1 << 62;
                            r_state <= S_SQY;
                        end else begin
                            r_ma <= r_rx[31:0]; r_mb <= r_root[31:0];
                            r_tstep <= '0;
                            r_state <= S_DEN;
                        end
                    end else begin
                        if (r_sqv >= w_sqsum) begin
                            r_sqv <= r_sqv - w_sqsum;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DEN: begin
                    r_tstep <= r_tstep + 1'b1;
                    if (r_tstep == 4'd1) begin
                        r_den <= r_prod;
                        r_neg <= r_cov[63];
                        r_rem <= '0; r_quo <= w_acov; r_dstep <= '0; r_ov <= 1'b0;
                        if (r_prod == '0) r_state <= S_EMIT;
                        else r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division over 64 quotient bits then 15 fraction bits
                    r_dstep <= r_dstep + 1'b1;
                    if (w_ge) begin
                        r_rem <= w_trial;
                    end else begin
                        r_rem <= w_rsh[63:0];
                    end
                    if (r_dstep == 7'd64 && r_quo > 64'd1) begin
                        // integer part above one counts as two
                        r_quo <= {61'd0, 2'd2, w_ge};
                    end else begin
                        r_quo <= {r_quo[62:0], w_ge};
                    end
                    if (r_dstep >= 7'd64 && r_dstep < 7'd79 && r_quo[63:17] != '0)
                        r_ov <= 1'b1;
                    if (r_dstep == 7'd79) begin
                        r_corr <= w_c;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_axis_tvalid) begin
                        m_axis_tdata[5:0] <= r_lag;
                        m_axis_tdata[21:6] <= r_corr;
                        if (w_mag > r_pmag) begin
                            r_pmag <= w_mag; r_plag <= r_lag; r_pc <= r_corr;
                            m_axis_tdata[27:22] <= r_lag;
                            m_axis_tdata[43:28] <= r_corr;
                        end else begin
                            m_axis_tdata[27:22] <= r_plag;
                            m_axis_tdata[43:28] <= r_pc;
                        end
                        m_axis_tdata[47:44] <= '0;
                        m_axis_tuser <= r_st_ovf ? ST_OVERFLOW : ST_OK;
                        m_axis_tlast <= (r_lag == r_limit);
                        m_axis_tvalid <= 1'b1;
                        if (r_lag == r_limit) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_lag <= r_lag + 1'b1;
                            r_state <= S_LAGINIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (!m_axis_tvalid) r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
        end
    end
endmodule

[src/lxcp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxcp_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module lxcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/lxcp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxcp_checker
// port-level checks for the lagged cross-correlation peak block
// ----------------------------------------------------------------------------
module lxcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import lxcp_pkg::*;

    // no input taken while a result is pending
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_LAG_ERR |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("error result malformed");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_LAG_ERR
            || m_axis_tuser == ST_OVERFLOW)) else $error("bad status");
endmodule

bind lagged_cross_correlation_peak lxcp_checker u_chk (.*);

[dv/lagged_cross_correlation_peak_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_cross_correlation_peak_tb
// Drives sets of sample pairs over the input stream, with lag_limit changed
// between sets. A local model works out the per-lag correlation results, and
// each output item is checked field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module lagged_cross_correlation_peak_tb;
    import lxcp_pkg::*;

    typedef struct packed {
        logic        fin;
        logic [15:0] follow;
        logic [15:0] lead;
    } t_pair;

    typedef struct packed {
        logic        last;
        logic [1:0]  status;
        logic [15:0] pcorr;
        logic [5:0]  plag;
        logic [15:0] corr;
        logic [5:0]  lag;
    } t_corr_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    lagged_cross_correlation_peak i_dut (.*);

    // model state
    logic signed [15:0] lead_mem [MAX_SAMPLES];
    logic signed [15:0] follow_mem [MAX_SAMPLES];
    int          stored_pairs;
    bit          dropped;
    logic [5:0]  lag_reg;

    t_corr_res   pending_results[$];
    t_pair       pair_q[$];
    int          fail_count;
    bit          hold_off;
    bit          calm;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("lagged_cross_correlation_peak_tb failed");
        $finish;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] pearson_q15(int n, int lag);
        longint sx, sy, sxx, syy, sxy, cov, vx, vy, x, y;
        longint unsigned den, mag, ip, rem, f;
        int m;
        sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        m = n - lag;
        if (lag >= n || m < 2) return 0;
        for (int i = 0; i < m; i++) begin
            x = lead_mem[i];
            y = follow_mem[i + lag];
            sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
        end
        cov = m * sxy - sx * sy;
        vx  = m * sxx - sx * sx;
        vy  = m * syy - sy * sy;
        if (vx <= 0 || vy <= 0) return 0;
        den = root_floor(vx) * root_floor(vy);
        if (den == 0) return 0;
        mag = cov < 0 ? -cov : cov;
        ip = mag / den;
        rem = mag % den;
        if (ip > 1) ip = 2;
        f = ip;
        for (int k = 0; k < 15; k++) begin
            rem <<= 1;
            f <<= 1;
            if (rem >= den) begin
                rem -= den;
                f |= 1;
            end
        end
        if (cov < 0) return f >= 32768 ? -16'sd32768 : -$signed(16'(f));
        return f >= 32767 ? 16'sd32767 : 16'(f);
    endfunction

    function automatic void predict_pair(t_pair p);
        int n, lim, pmag, mag;
        logic signed [15:0] c, pc;
        logic [5:0] plag;
        logic [1:0] st;
        pc = 0; plag = 0; pmag = 0;
        if (stored_pairs < MAX_SAMPLES) begin
            lead_mem[stored_pairs]   = p.lead;
            follow_mem[stored_pairs] = p.follow;
            stored_pairs++;
        end else begin
            dropped = 1;
        end
        if (!p.fin) return;
        n = stored_pairs;
        st = dropped ? ST_OVERFLOW : ST_OK;
        stored_pairs = 0;
        dropped = 0;
        lim = lag_reg;
        if (lim >= n) begin
            pending_results.insert(pending_results.size(),
                t_corr_res'{1'b1, ST_LAG_ERR, 16'd0, 6'd0, 16'd0, 6'd0});
            return;
        end
        for (int lag = 0; lag <= lim; lag++) begin
            c = pearson_q15(n, lag);
            mag = c < 0 ? -int'(c) : int'(c);
            if (mag > pmag) begin
                pmag = mag; plag = 6'(lag); pc = c;
            end
            pending_results.insert(pending_results.size(),
                t_corr_res'{lag == lim, st, pc, plag, c, 6'(lag)});
        end
    endfunction

    // receiver with random stalls, and a long hold-off on request
    initial begin
        t_corr_res got, want;
        m_axis_tready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tuser, m_axis_tdata[43:0]};
                if (pending_results.size() == 0) begin
                    $error("unexpected result item %h", got);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.lag !== want.lag) begin
                        $error("lag_index exp %0d got %0d", want.lag, got.lag); fail_count++;
                    end
                    if (got.corr !== want.corr) begin
                        $error("corr_value exp %0d got %0d", $signed(want.corr),
                               $signed(got.corr)); fail_count++;
                    end
                    if (got.plag !== want.plag) begin
                        $error("peak_lag exp %0d got %0d", want.plag, got.plag); fail_count++;
                    end
                    if (got.pcorr !== want.pcorr) begin
                        $error("peak_corr exp %0d got %0d", $signed(want.pcorr),
                               $signed(got.pcorr)); fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status_code exp %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("run_end exp %0d got %0d", want.last, got.last); fail_count++;
                    end
                end
            end
            m_axis_tready <= hold_off ? 1'b0 : (calm || $urandom_range(99) >= 22);
        end
    end

    task automatic write_lag_limit(logic [7:0] v);
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        lag_reg = v[5:0];
    endtask

    // sends the queued pairs and waits until every result has arrived
    task automatic run_set();
        t_pair p;
        while (pair_q.size() > 0) begin
            p = pair_q.pop_front();
            if (!calm) begin
                while ($urandom_range(99) < 22) begin
                    s_axis_tvalid <= 0;
                    @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 1;
            s_axis_tdata  <= {p.follow, p.lead};
            s_axis_tlast  <= p.fin;
            do @(posedge i_clk); while (!s_axis_tready);
            predict_pair(p);
        end
        s_axis_tvalid <= 0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic queue_random_set(int n, int kind);
        t_pair p;
        logic [15:0] a, b;
        for (int i = 0; i < n; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (kind)
                1: b = a + 16'($urandom_range(0, 200)) - 16'd100;
                2: b = -a;
                3: begin a = 16'($urandom_range(0, 3)) << 14; b = ~a; end
                default: ;
            endcase
            p.lead = a; p.follow = b; p.fin = (i == n - 1);
            pair_q.insert(pair_q.size(), p);
        end
    endtask

    // directed rows: last, follow, lead
    t_pair directed_rows[$] = '{
        '{1'b1, 16'h7fff, 16'h8000},                       // single pair, too few for a correlation
        '{1'b0, 16'h0001, 16'h0001}, '{1'b0, 16'h0002, 16'h0002},
        '{1'b0, 16'h0003, 16'h0003}, '{1'b1, 16'h0004, 16'h0004},
        '{1'b0, 16'h8000, 16'h7fff}, '{1'b0, 16'h7fff, 16'h8000},
        '{1'b0, 16'h8000, 16'h7fff}, '{1'b1, 16'h7fff, 16'h8000},
        '{1'b0, 16'h1234, 16'h0005}, '{1'b0, 16'hffff, 16'h0005},  // flat lead
        '{1'b1, 16'h0000, 16'h0005}
    };

    initial begin
        fail_count = 0; hold_off = 0; calm = 0;
        stored_pairs = 0; dropped = 0; lag_reg = 0;
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset lag_limit of 0 against a single pair: one zero correlation expected directly
        pair_q.insert(pair_q.size(), directed_rows[0]);
        run_set();
        write_lag_limit(8'd2);
        for (int i = 1; i < directed_rows.size(); i++)
            pair_q.insert(pair_q.size(), directed_rows[i]);
        run_set();
        // lag limit equal to the count, then a limit with the top bits set, cut to its low six bits
        write_lag_limit(8'd3);
        queue_random_set(3, 0); run_set();
        write_lag_limit(8'hff);
        queue_random_set(70, 1); run_set();
        // overflow: more pairs than the store holds, with a short lag range
        write_lag_limit(8'd1);
        calm = 1;
        queue_random_set(MAX_SAMPLES + 3, 0); run_set();
        calm = 0;

        // random sets, long receiver hold-off with a second set offered behind
        for (int s = 0; s < 30; s++) begin
            write_lag_limit($urandom_range(0, 12) == 0 ? 8'd63 : 8'($urandom_range(0, 8)));
            queue_random_set($urandom_range(1, 12), $urandom_range(0, 3));
            if (s == 5) begin
                queue_random_set($urandom_range(1, 12), $urandom_range(0, 3));
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            calm = (s >= 20 && s < 25);
            run_set();
        end
        calm = 0;

        if (fail_count == 0) begin
            $display("lagged_cross_correlation_peak_tb passed");
        end else begin
            $display("lagged_cross_correlation_peak_tb failed");
        end
        $finish;
    end
endmodule

[filelist.f]
src/lxcp_pkg.sv
src/lxcp_ram.sv
src/lagged_cross_correlation_peak.sv
src/lxcp_checker.sv
dv/lagged_cross_correlation_peak_tb.sv
